// ===== rtl/core/ffha_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the first-fit heap allocator.
// Used by the block cells, the controller and the top level; depends on nothing.
package ffha_pkg;

    localparam int MODE_W       = 2;
    localparam int REQ_W        = 24;
    localparam int ADDR_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int HEAP_SIZE_W  = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [HEAP_SIZE_W-1:0] HEAP_SIZE_RESET = 24'd1048576;

    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_BASE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEAP_SIZE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_REINIT = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_FIT  = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_IDLE       = 3'd0,
        OP_SCAN_ALLOC = 3'd1,
        OP_SCAN_FREE  = 3'd2,
        OP_REINIT     = 3'd3,
        OP_MARK       = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_SPLIT      = 3'd6,
        OP_MERGE      = 3'd7
    } cell_op_t;

    typedef struct packed {
        logic hit;
        logic fin;
        logic split_ok;
        logic prev_free;
        logic next_free;
    } ffha_rpt_t;

endpackage

// ===== rtl/core/ffha_cell.sv =====
`timescale 1ns / 1ps
// One cell of the block table: holds one heap block and the search token.
// Depends on ffha_pkg; neighbors are wired by the top level.
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int INDEX        = 0,
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 16,
    parameter int OFFSET_BITS  = 24,
    parameter int unsigned RESET_SIZE = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_op_t                    op,
    input  logic [$clog2(MAX_BLOCKS)-1:0] pos,
    input  logic [REQ_W-1:0]            req,
    input  logic [ADDR_W-1:0]           target,
    input  logic [OFFSET_BITS-1:0]      fill,
    input  logic [2*OFFSET_BITS+1:0]    left,
    input  logic [2*OFFSET_BITS+1:0]    right,
    input  logic                        tok_in,
    output logic [2*OFFSET_BITS+1:0]    entry,
    output logic                        tok_out,
    output ffha_rpt_t                   rpt
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int OB = OFFSET_BITS;
    localparam int EW = 2 * OB + 2;
    localparam int CW = ((OB > REQ_W) ? OB : REQ_W) + 1;
    localparam logic [IW:0] IDX = (IW + 1)'(INDEX);

    logic          valid_reg, valid_next;
    logic          used_reg, used_next;
    logic [OB-1:0] start_reg, start_next;
    logic [OB-1:0] size_reg, size_next;
    logic          tok_reg;

    logic          l_valid, l_used, r_valid, r_used;
    logic [OB-1:0] l_start, l_size, r_size;
    logic [CW-1:0] size_x, req_x, rem_x, hdr_x;
    logic          fit, split_ok, addr_hit, match;
    logic [IW:0]   p, p1;

    assign l_valid = left[EW-1];
    assign l_used  = left[EW-2];
    assign l_start = left[2*OB-1:OB];
    assign l_size  = left[OB-1:0];
    assign r_valid = right[EW-1];
    assign r_used  = right[EW-2];
    assign r_size  = right[OB-1:0];

    assign size_x   = CW'(size_reg);
    assign req_x    = CW'(req);
    assign hdr_x    = CW'(HEADER_BYTES);
    assign rem_x    = size_x - req_x;
    assign fit      = size_x >= req_x;
    assign split_ok = fit && (rem_x >= hdr_x);
    assign addr_hit = ADDR_W'(start_reg) == target;

    always_comb
    begin
        match = 1'b0;
        if (op == OP_SCAN_ALLOC)
        begin
            match = !used_reg && fit;
        end
        else if (op == OP_SCAN_FREE)
        begin
            match = used_reg && addr_hit;
        end
    end

    assign rpt.hit       = tok_reg && valid_reg && match;
    assign rpt.fin       = tok_reg && !valid_reg;
    assign rpt.split_ok  = split_ok;
    assign rpt.prev_free = l_valid && !l_used;
    assign rpt.next_free = r_valid && !r_used;
    assign tok_out       = tok_reg && valid_reg && !match;

    assign entry = {valid_reg, used_reg, start_reg, size_reg};

    assign p  = {1'b0, pos};
    assign p1 = p + (IW + 1)'(1);

    always_comb
    begin
        valid_next = valid_reg;
        used_next  = used_reg;
        start_next = start_reg;
        size_next  = size_reg;
        unique case (op)
            OP_REINIT:
            begin
                if (IDX == '0)
                begin
                    valid_next = 1'b1;
                    used_next  = 1'b0;
                    start_next = '0;
                    size_next  = fill;
                end
                else
                begin
                    valid_next = 1'b0;
                end
            end
            OP_MARK:
            begin
                if (IDX == p)
                begin
                    used_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                if (IDX == p)
                begin
                    used_next = 1'b0;
                end
            end
            OP_SPLIT:
            begin
                if (IDX == p)
                begin
                    size_next = OB'(req_x);
                    used_next = 1'b1;
                end
                else if (IDX == p1)
                begin
                    valid_next = 1'b1;
                    used_next  = 1'b0;
                    start_next = OB'(CW'(l_start) + hdr_x + req_x);
                    size_next  = OB'(CW'(l_size) - req_x - hdr_x);
                end
                else if (IDX > p1)
                begin
                    {valid_next, used_next, start_next, size_next} = left;
                end
            end
            OP_MERGE:
            begin
                if (IDX == p)
                begin
                    size_next = OB'(size_x + hdr_x + CW'(r_size));
                    used_next = 1'b0;
                end
                else if (IDX > p)
                begin
                    {valid_next, used_next, start_next, size_next} = right;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= (INDEX == 0);
            used_reg  <= 1'b0;
            start_reg <= '0;
            size_reg  <= (INDEX == 0) ? OB'(RESET_SIZE) : '0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            start_reg <= start_next;
            size_reg  <= size_next;
            tok_reg   <= tok_in;
        end
    end

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer of the allocator: starts the table scan, turns the hit
// report into table updates and holds the result beat. Depends on ffha_pkg.
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 16,
    parameter int OFFSET_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [MODE_W-1:0]             mode,
    input  logic [REQ_W-1:0]              request_size,
    input  logic [ADDR_W-1:0]             block_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [STATUS_W-1:0]           status,
    output logic [ADDR_W-1:0]             payload_address,
    input  logic [ADDR_W-1:0]             heap_base,
    input  logic [HEAP_SIZE_W-1:0]        heap_size,
    output cell_op_t                      cell_op,
    output logic [$clog2(MAX_BLOCKS)-1:0] cell_pos,
    output logic [REQ_W-1:0]              cell_req,
    output logic [ADDR_W-1:0]             cell_target,
    output logic [OFFSET_BITS-1:0]        cell_fill,
    output logic                          tok_start,
    input  logic [2*OFFSET_BITS+1:0]      entries [MAX_BLOCKS],
    input  ffha_rpt_t                     rpts [MAX_BLOCKS],
    input  logic                          tail_tok
);

    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int OB   = OFFSET_BITS;
    localparam int CW   = ((OB > REQ_W) ? OB : REQ_W) + 1;
    localparam logic [CW-1:0] OFFSET_MASK = CW'((64'd1 << OB) - 64'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE_PREV,
        S_DONE
    } state_t;

    state_t          state_reg;
    cell_op_t        op_reg;
    logic [IW-1:0]   pos_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] target_reg;
    logic [OB-1:0]   fill_reg;
    logic            tok_start_reg;
    logic [CNTW-1:0] count_reg;
    status_t         status_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic            out_valid_reg;
    status_t         out_status_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    logic            any_hit, any_fin, hit_split, hit_prev, hit_next;
    logic [IW-1:0]   hit_idx;
    logic [OB-1:0]   hit_start;
    logic [ADDR_W-1:0] hit_addr, free_target;
    logic [CW-1:0]   total_x;
    logic [OB-1:0]   fill_c;

    always_comb
    begin
        any_hit   = 1'b0;
        any_fin   = tail_tok;
        hit_split = 1'b0;
        hit_prev  = 1'b0;
        hit_next  = 1'b0;
        hit_idx   = '0;
        hit_start = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            any_fin = any_fin | rpts[i].fin;
            if (rpts[i].hit)
            begin
                any_hit   = 1'b1;
                hit_split = hit_split | rpts[i].split_ok;
                hit_prev  = hit_prev | rpts[i].prev_free;
                hit_next  = hit_next | rpts[i].next_free;
                hit_idx   = hit_idx | IW'(i);
                hit_start = hit_start | entries[i][2*OB-1:OB];
            end
        end
    end

    assign hit_addr    = heap_base + ADDR_W'(hit_start) + ADDR_W'(HEADER_BYTES);
    assign free_target = block_address - heap_base - ADDR_W'(HEADER_BYTES);

    always_comb
    begin
        total_x = CW'(heap_size);
        if (total_x > OFFSET_MASK)
        begin
            total_x = OFFSET_MASK;
        end
        fill_c = '0;
        if (total_x > CW'(HEADER_BYTES))
        begin
            fill_c = OB'(total_x - CW'(HEADER_BYTES));
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign payload_address = out_addr_reg;
    assign cell_op         = op_reg;
    assign cell_pos        = pos_reg;
    assign cell_req        = req_reg;
    assign cell_target     = target_reg;
    assign cell_fill       = fill_reg;
    assign tok_start       = tok_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_IDLE;
            pos_reg        <= '0;
            req_reg        <= '0;
            target_reg     <= '0;
            fill_reg       <= '0;
            tok_start_reg  <= 1'b0;
            count_reg      <= CNTW'(1);
            status_reg     <= STATUS_OK;
            addr_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_addr_reg   <= '0;
        end
        else
        begin
            tok_start_reg <= 1'b0;
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        status_reg <= STATUS_OK;
                        addr_reg   <= '0;
                        unique case (mode_t'(mode))
                            MODE_ALLOC:
                            begin
                                op_reg        <= OP_SCAN_ALLOC;
                                req_reg       <= request_size;
                                tok_start_reg <= 1'b1;
                                state_reg     <= S_SCAN;
                            end
                            MODE_FREE:
                            begin
                                if (block_address == '0)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    op_reg        <= OP_SCAN_FREE;
                                    target_reg    <= free_target;
                                    tok_start_reg <= 1'b1;
                                    state_reg     <= S_SCAN;
                                end
                            end
                            MODE_REINIT:
                            begin
                                op_reg    <= OP_REINIT;
                                fill_reg  <= fill_c;
                                count_reg <= CNTW'(1);
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (any_hit)
                    begin
                        pos_reg <= hit_idx;
                        if (op_reg == OP_SCAN_ALLOC)
                        begin
                            state_reg <= S_DONE;
                            if (hit_split && (count_reg == CNTW'(MAX_BLOCKS)))
                            begin
                                status_reg <= STATUS_FULL;
                                op_reg     <= OP_IDLE;
                            end
                            else if (hit_split)
                            begin
                                op_reg    <= OP_SPLIT;
                                count_reg <= count_reg + CNTW'(1);
                                addr_reg  <= hit_addr;
                            end
                            else
                            begin
                                op_reg   <= OP_MARK;
                                addr_reg <= hit_addr;
                            end
                        end
                        else
                        begin
                            if (hit_next)
                            begin
                                op_reg    <= OP_MERGE;
                                count_reg <= count_reg - CNTW'(1);
                            end
                            else
                            begin
                                op_reg <= OP_CLEAR;
                            end
                            state_reg <= hit_prev ? S_MERGE_PREV : S_DONE;
                        end
                    end
                    else if (any_fin)
                    begin
                        status_reg <= (op_reg == OP_SCAN_ALLOC) ? STATUS_NO_FIT
                                                                : STATUS_UNKNOWN;
                        op_reg     <= OP_IDLE;
                        state_reg  <= S_DONE;
                    end
                end
                S_MERGE_PREV:
                begin
                    op_reg    <= OP_MERGE;
                    pos_reg   <= pos_reg - IW'(1);
                    count_reg <= count_reg - CNTW'(1);
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    op_reg <= OP_IDLE;
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        out_addr_reg   <= addr_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// First-fit heap allocator with coalescing: configuration registers, the
// request sequencer and the chain of block cells. Depends on ffha_pkg,
// ffha_cell and ffha_ctrl.
//
// Requests arrive as beats on the in channel (mode, request_size,
// block_address); each request yields exactly one result beat on the out
// channel (status, payload_address). Both channels use valid and ready.
// The block table is a chain of MAX_BLOCKS cells. A search token walks the
// chain one cell per cycle, from the first cell up to the block found; a
// free whose previous block is free passes through an extra merge state.
// Null frees, reinitialize and no-operation requests skip the scan and go
// straight to the result. One request is in work at a time; the next beat
// is taken as soon as the result is written to the output register, even
// if that beat still waits for the receiver. A result that cannot be
// written because the receiver stalls holds the block until the output
// register frees up.
// After reset the heap is 1 MiB (saturated to the offset range), one free
// block less its header, at heap_base 0. Configuration writes are always
// taken; heap_size takes effect at the next reinitialize request.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 16,
    parameter int HEADER_BYTES = 16,
    parameter int OFFSET_BITS  = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [REQ_W-1:0]       request_size,
    input  logic [ADDR_W-1:0]      block_address,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [ADDR_W-1:0]      payload_address,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int EW = 2 * OFFSET_BITS + 2;
    localparam longint unsigned OFFSET_MASK = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam longint unsigned RESET_TOTAL =
        (64'(HEAP_SIZE_RESET) < OFFSET_MASK) ? 64'(HEAP_SIZE_RESET) : OFFSET_MASK;
    localparam longint unsigned RESET_SIZE_L =
        (RESET_TOTAL > 64'(HEADER_BYTES)) ? RESET_TOTAL - 64'(HEADER_BYTES) : 64'd0;
    localparam int unsigned RESET_SIZE = 32'(RESET_SIZE_L);

    logic [ADDR_W-1:0]      heap_base_reg;
    logic [HEAP_SIZE_W-1:0] heap_size_reg;

    cell_op_t               cell_op;
    logic [IW-1:0]          cell_pos;
    logic [REQ_W-1:0]       cell_req;
    logic [ADDR_W-1:0]      cell_target;
    logic [OFFSET_BITS-1:0] cell_fill;
    logic                   tok_start;
    logic [EW-1:0]          entry_w [MAX_BLOCKS];
    ffha_rpt_t              rpt_w [MAX_BLOCKS];
    logic                   tok_w [MAX_BLOCKS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            heap_size_reg <= HEAP_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HEAP_BASE: heap_base_reg <= cfg_data;
                REG_HEAP_SIZE: heap_size_reg <= cfg_data[HEAP_SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ffha_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .request_size    (request_size),
        .block_address   (block_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .payload_address (payload_address),
        .heap_base       (heap_base_reg),
        .heap_size       (heap_size_reg),
        .cell_op         (cell_op),
        .cell_pos        (cell_pos),
        .cell_req        (cell_req),
        .cell_target     (cell_target),
        .cell_fill       (cell_fill),
        .tok_start       (tok_start),
        .entries         (entry_w),
        .rpts            (rpt_w),
        .tail_tok        (tok_w[MAX_BLOCKS])
    );

    assign tok_w[0] = tok_start;

    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        logic [EW-1:0] left_w;
        logic [EW-1:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[g-1];
        end

        if (g == MAX_BLOCKS - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[g+1];
        end

        ffha_cell #(
            .INDEX        (g),
            .MAX_BLOCKS   (MAX_BLOCKS),
            .HEADER_BYTES (HEADER_BYTES),
            .OFFSET_BITS  (OFFSET_BITS),
            .RESET_SIZE   (RESET_SIZE)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .op      (cell_op),
            .pos     (cell_pos),
            .req     (cell_req),
            .target  (cell_target),
            .fill    (cell_fill),
            .left    (left_w),
            .right   (right_w),
            .tok_in  (tok_w[g]),
            .entry   (entry_w[g]),
            .tok_out (tok_w[g+1]),
            .rpt     (rpt_w[g])
        );
    end

endmodule
